[hdl/crcs_pkg.sv]
// Shared widths, codes and controller/datapath interface types for the circle region stats block.
`default_nettype none

package crcs_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_MAX_HEIGHT  = 1024;
  localparam int DEF_EDGE_MARGIN = 2;

  localparam int PIX_W      = 8;
  localparam int COORD_W    = 10;
  localparam int IW_W       = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int CNT_W    = 21;
  localparam int SUM_W    = 29;
  localparam int SQS_W    = 37;
  localparam int MEAN_W   = 16;
  localparam int VAR_W    = 24;
  localparam int STATUS_W = 2;

  localparam int MUL_AW = 37;
  localparam int MUL_BW = 29;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int DEN_W  = 42;
  localparam int NUM_W  = 58;
  localparam int DIV_NW = 66;
  localparam int DIV_DW = 42;
  localparam int DIV_QW = 24;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [IW_W-1:0]  WIDTH_RESET = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SINGLE = 2'd2;

  localparam logic [1:0] MSEL_DEN = 2'd0;
  localparam logic [1:0] MSEL_SQ  = 2'd1;
  localparam logic [1:0] MSEL_SS  = 2'd2;

  localparam logic DSEL_MEAN = 1'b0;
  localparam logic DSEL_VAR  = 1'b1;

  typedef struct packed {
    logic       accept_en;
    logic       clr_res;
    logic       mul_start;
    logic [1:0] mul_sel;
    logic       save_den;
    logic       save_p1;
    logic       save_num;
    logic       div_start;
    logic       div_sel;
    logic       save_mean;
    logic       save_var;
    logic       finish;
    logic [1:0] ch;
  } crcs_cmd_t;

  typedef struct packed {
    logic last_acc;
    logic mul_done;
    logic div_done;
    logic n_zero;
    logic n_one;
    logic out_free;
  } crcs_stat_t;

endpackage

`default_nettype wire

[hdl/crcs_mul.sv]
// Shift-and-add multiplier, one multiplier bit per cycle.
`default_nettype none

module crcs_mul (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [crcs_pkg::MUL_AW-1:0] a,
  input  wire logic [crcs_pkg::MUL_BW-1:0] b,
  output logic                            done,
  output logic [crcs_pkg::MUL_PW-1:0]     prod
);

  localparam int CW = $clog2(crcs_pkg::MUL_BW);
  localparam logic [CW-1:0] LAST = CW'(crcs_pkg::MUL_BW - 1);

  logic                        run;
  logic [CW-1:0]               cnt;
  logic [crcs_pkg::MUL_PW-1:0] ma;
  logic [crcs_pkg::MUL_BW-1:0] mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == LAST) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma   <= {{crcs_pkg::MUL_BW{1'b0}}, a};
      mb   <= b;
      prod <= '0;
      cnt  <= '0;
    end else if (run) begin
      if (mb[0]) begin
        prod <= prod + ma;
      end
      ma  <= {ma[crcs_pkg::MUL_PW-2:0], 1'b0};
      mb  <= {1'b0, mb[crcs_pkg::MUL_BW-1:1]};
      cnt <= cnt + CW'(1);
    end
  end

endmodule

`default_nettype wire

[hdl/crcs_div.sv]
// Restoring divider that develops one quotient bit per cycle.
`default_nettype none

module crcs_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [crcs_pkg::DIV_NW-1:0] num,
  input  wire logic [crcs_pkg::DIV_DW-1:0] den,
  output logic                            done,
  output logic [crcs_pkg::DIV_QW-1:0]     quo
);

  localparam int DW = crcs_pkg::DIV_DW;
  localparam int QW = crcs_pkg::DIV_QW;
  localparam int CW = $clog2(QW);
  localparam logic [CW-1:0] LAST = CW'(QW - 1);

  logic          run;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] dreg;
  logic [DW:0]   trial;
  logic [DW+1:0] diff;
  logic          ge;

  // The quotient is known to fit in QW bits, so the upper dividend bits
  // already lie below the divisor and seed the remainder directly.
  assign trial = {rem, quo[QW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dreg};
  assign ge    = ~diff[DW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == LAST) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num[crcs_pkg::DIV_NW-1:QW];
      quo  <= num[QW-1:0];
      dreg <= den;
      cnt  <= '0;
    end else if (run) begin
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo <= {quo[QW-2:0], ge};
      cnt <= cnt + CW'(1);
    end
  end

endmodule

`default_nettype wire

[hdl/crcs_dp.sv]
// Datapath: configuration, position counters, inclusion test, accumulators and result math.
`default_nettype none

module crcs_dp #(
  parameter int MAX_WIDTH   = crcs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = crcs_pkg::DEF_MAX_HEIGHT,
  parameter int EDGE_MARGIN = crcs_pkg::DEF_EDGE_MARGIN
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [crcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [crcs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  input  wire logic [crcs_pkg::PIX_W-1:0]      blue,
  input  wire logic [crcs_pkg::PIX_W-1:0]      green,
  input  wire logic [crcs_pkg::PIX_W-1:0]      red,
  input  wire logic                           frame_end,
  input  wire logic                           out_stall,
  output logic                                out_valid,
  output logic [crcs_pkg::CNT_W-1:0]          pixel_count,
  output logic [crcs_pkg::MEAN_W-1:0]         mean_blue,
  output logic [crcs_pkg::MEAN_W-1:0]         mean_green,
  output logic [crcs_pkg::MEAN_W-1:0]         mean_red,
  output logic [crcs_pkg::VAR_W-1:0]          var_blue,
  output logic [crcs_pkg::VAR_W-1:0]          var_green,
  output logic [crcs_pkg::VAR_W-1:0]          var_red,
  output logic [crcs_pkg::STATUS_W-1:0]       status,
  input  wire crcs_pkg::crcs_cmd_t             cmd,
  output crcs_pkg::crcs_stat_t                 stat
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int XW  = ((CW > crcs_pkg::COORD_W) ? CW : crcs_pkg::COORD_W) + 1;
  localparam int YW  = ((RW > crcs_pkg::COORD_W) ? RW : crcs_pkg::COORD_W) + 1;
  localparam int SW  = (XW > YW) ? XW : YW;
  localparam int DSW = 2 * SW;
  localparam int D2W = 2 * SW + 1;
  localparam int WW  = ((CW > crcs_pkg::IW_W) ? CW : crcs_pkg::IW_W) + 1;
  localparam int PW  = crcs_pkg::PIX_W;
  localparam int PSW = 2 * PW;
  localparam int R2W = 2 * crcs_pkg::COORD_W;

  localparam logic [WW-1:0] WMAX = WW'(MAX_WIDTH);
  localparam logic [RW-1:0] ROW_LAST = RW'(MAX_HEIGHT - 1);
  localparam logic [crcs_pkg::COORD_W-1:0] MARGIN = crcs_pkg::COORD_W'(EDGE_MARGIN);

  // Configuration registers
  logic [crcs_pkg::COORD_W-1:0] center_x;
  logic [crcs_pkg::COORD_W-1:0] center_y;
  logic [crcs_pkg::COORD_W-1:0] radius;
  logic [crcs_pkg::IW_W-1:0]    image_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_y    <= '0;
      radius      <= '0;
      image_width <= crcs_pkg::WIDTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        crcs_pkg::REG_CENTER_X: center_x    <= cfg_data[crcs_pkg::COORD_W-1:0];
        crcs_pkg::REG_CENTER_Y: center_y    <= cfg_data[crcs_pkg::COORD_W-1:0];
        crcs_pkg::REG_RADIUS:   radius      <= cfg_data[crcs_pkg::COORD_W-1:0];
        crcs_pkg::REG_WIDTH:    image_width <= cfg_data[crcs_pkg::IW_W-1:0];
        default: ;
      endcase
    end
  end

  // Squared inclusion radius, refreshed every cycle from the radius register.
  logic [crcs_pkg::COORD_W-1:0] rr;
  logic [R2W-1:0]               r2;
  logic                         r_ok;

  assign rr = radius - MARGIN;

  always_ff @(posedge clk) begin
    r2   <= R2W'(rr) * R2W'(rr);
    r_ok <= (radius >= MARGIN);
  end

  // Position counters
  logic          in_accept;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [WW-1:0] iw_ext;
  logic [WW-1:0] w_eff;
  logic [WW-1:0] col_inc;

  assign in_accept = in_valid && cmd.accept_en;
  assign iw_ext    = WW'(image_width);
  assign w_eff     = (iw_ext == '0) ? WW'(1) : ((iw_ext > WMAX) ? WMAX : iw_ext);
  assign col_inc   = WW'(col) + WW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (in_accept) begin
      if (frame_end) begin
        col <= '0;
        row <= '0;
      end else if (col_inc >= w_eff) begin
        col <= '0;
        row <= (row == ROW_LAST) ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // Stage 1: distance squares and pixel squares
  logic signed [SW-1:0]   dx;
  logic signed [SW-1:0]   dy;
  logic signed [2*SW-1:0] dx_sq;
  logic signed [2*SW-1:0] dy_sq;
  logic [PW-1:0]          px_in [3];

  assign dx    = $signed(SW'(col)) - $signed(SW'(center_x));
  assign dy    = $signed(SW'(row)) - $signed(SW'(center_y));
  assign dx_sq = DSW'(dx) * DSW'(dx);
  assign dy_sq = DSW'(dy) * DSW'(dy);
  assign px_in[0] = blue;
  assign px_in[1] = green;
  assign px_in[2] = red;

  logic            s1_valid;
  logic [2*SW-1:0] s1_dx2;
  logic [2*SW-1:0] s1_dy2;
  logic [PW-1:0]   s1_px [3];
  logic [2*PW-1:0] s1_sq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_dx2 <= unsigned'(dx_sq);
      s1_dy2 <= unsigned'(dy_sq);
      for (int c = 0; c < 3; c++) begin
        s1_px[c] <= px_in[c];
        s1_sq[c] <= PSW'(px_in[c]) * PSW'(px_in[c]);
      end
    end
  end

  // Stage 2: inclusion test and accumulation
  logic [crcs_pkg::CNT_W-1:0] count;
  logic [crcs_pkg::SUM_W-1:0] sum [3];
  logic [crcs_pkg::SQS_W-1:0] sqs [3];
  logic [D2W-1:0]             d2;
  logic                       in_region;

  assign d2        = {1'b0, s1_dx2} + {1'b0, s1_dy2};
  assign in_region = s1_valid && r_ok && (d2 <= D2W'(r2)) &&
                     (count != crcs_pkg::COUNT_MAX);

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      count <= '0;
      for (int c = 0; c < 3; c++) begin
        sum[c] <= '0;
        sqs[c] <= '0;
      end
    end else if (in_region) begin
      count <= count + crcs_pkg::CNT_W'(1);
      for (int c = 0; c < 3; c++) begin
        sum[c] <= sum[c] + crcs_pkg::SUM_W'(s1_px[c]);
        sqs[c] <= sqs[c] + crcs_pkg::SQS_W'(s1_sq[c]);
      end
    end
  end

  // Channel selection for the shared multiplier and divider
  logic [crcs_pkg::SUM_W-1:0] sel_sum;
  logic [crcs_pkg::SQS_W-1:0] sel_sqs;

  always_comb begin
    case (cmd.ch)
      2'd0: begin
        sel_sum = sum[0];
        sel_sqs = sqs[0];
      end
      2'd1: begin
        sel_sum = sum[1];
        sel_sqs = sqs[1];
      end
      default: begin
        sel_sum = sum[2];
        sel_sqs = sqs[2];
      end
    endcase
  end

  logic [crcs_pkg::CNT_W-1:0]  count_m1;
  logic [crcs_pkg::MUL_AW-1:0] mul_a;
  logic [crcs_pkg::MUL_BW-1:0] mul_b;
  logic                        mul_done;
  logic [crcs_pkg::MUL_PW-1:0] mul_prod;

  assign count_m1 = count - crcs_pkg::CNT_W'(1);

  always_comb begin
    case (cmd.mul_sel)
      crcs_pkg::MSEL_DEN: begin
        mul_a = crcs_pkg::MUL_AW'(count);
        mul_b = crcs_pkg::MUL_BW'(count_m1);
      end
      crcs_pkg::MSEL_SQ: begin
        mul_a = sel_sqs;
        mul_b = crcs_pkg::MUL_BW'(count);
      end
      crcs_pkg::MSEL_SS: begin
        mul_a = crcs_pkg::MUL_AW'(sel_sum);
        mul_b = sel_sum;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  crcs_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // n*(n-1), n*sumsq, and n*sumsq - sum^2
  logic [crcs_pkg::DEN_W-1:0] den_r;
  logic [crcs_pkg::NUM_W-1:0] p1_r;
  logic [crcs_pkg::NUM_W-1:0] num_r;

  always_ff @(posedge clk) begin
    if (cmd.save_den) begin
      den_r <= mul_prod[crcs_pkg::DEN_W-1:0];
    end
    if (cmd.save_p1) begin
      p1_r <= mul_prod[crcs_pkg::NUM_W-1:0];
    end
    if (cmd.save_num) begin
      num_r <= p1_r - mul_prod[crcs_pkg::NUM_W-1:0];
    end
  end

  logic [crcs_pkg::DIV_NW-1:0] div_num;
  logic [crcs_pkg::DIV_DW-1:0] div_den;
  logic                        div_done;
  logic [crcs_pkg::DIV_QW-1:0] div_quo;

  always_comb begin
    if (cmd.div_sel == crcs_pkg::DSEL_VAR) begin
      div_num = {num_r, 8'h00};
      div_den = den_r;
    end else begin
      div_num = crcs_pkg::DIV_NW'({sel_sum, 8'h00});
      div_den = crcs_pkg::DIV_DW'(count);
    end
  end

  crcs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Per-channel results
  logic [crcs_pkg::MEAN_W-1:0] mean_r [3];
  logic [crcs_pkg::VAR_W-1:0]  var_r  [3];

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (cmd.clr_res) begin
        mean_r[c] <= '0;
        var_r[c]  <= '0;
      end else if (cmd.ch == 2'(c)) begin
        if (cmd.save_mean) begin
          mean_r[c] <= div_quo[crcs_pkg::MEAN_W-1:0];
        end
        if (cmd.save_var) begin
          var_r[c] <= div_quo[crcs_pkg::VAR_W-1:0];
        end
      end
    end
  end

  // Output register
  logic n_zero;
  logic n_one;

  assign n_zero = (count == '0);
  assign n_one  = (count == crcs_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      pixel_count <= count;
      mean_blue   <= mean_r[0];
      mean_green  <= mean_r[1];
      mean_red    <= mean_r[2];
      var_blue    <= var_r[0];
      var_green   <= var_r[1];
      var_red     <= var_r[2];
      status      <= n_zero ? crcs_pkg::ST_EMPTY :
                     (n_one ? crcs_pkg::ST_SINGLE : crcs_pkg::ST_OK);
    end
  end

  assign stat.last_acc = in_accept && frame_end;
  assign stat.mul_done = mul_done;
  assign stat.div_done = div_done;
  assign stat.n_zero   = n_zero;
  assign stat.n_one    = n_one;
  assign stat.out_free = !out_valid || !out_stall;

endmodule

`default_nettype wire

[hdl/crcs_ctrl.sv]
// Controller: pixel intake and the per-frame sequence of multiplies and divides.
`default_nettype none

module crcs_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire crcs_pkg::crcs_stat_t stat,
  output crcs_pkg::crcs_cmd_t       cmd
);

  localparam logic [3:0] S_ACC    = 4'd0;
  localparam logic [3:0] S_FLUSH  = 4'd1;
  localparam logic [3:0] S_START  = 4'd2;
  localparam logic [3:0] S_DEN    = 4'd3;
  localparam logic [3:0] S_MEAN   = 4'd4;
  localparam logic [3:0] S_MEAN_W = 4'd5;
  localparam logic [3:0] S_SQ     = 4'd6;
  localparam logic [3:0] S_SQ_W   = 4'd7;
  localparam logic [3:0] S_SS     = 4'd8;
  localparam logic [3:0] S_SS_W   = 4'd9;
  localparam logic [3:0] S_VAR    = 4'd10;
  localparam logic [3:0] S_VAR_W  = 4'd11;
  localparam logic [3:0] S_NEXT   = 4'd12;
  localparam logic [3:0] S_FIN    = 4'd13;

  localparam logic [1:0] CH_LAST = 2'd2;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] ch;
  logic [1:0] ch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
      ch    <= '0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.ch     = ch;
    state_next = state;
    ch_next    = ch;
    case (state)
      S_ACC: begin
        cmd.accept_en = 1'b1;
        if (stat.last_acc) begin
          state_next = S_FLUSH;
        end
      end
      // The last pixel is still one stage away from the accumulators.
      S_FLUSH: begin
        state_next = S_START;
      end
      S_START: begin
        cmd.clr_res = 1'b1;
        ch_next     = '0;
        if (stat.n_zero) begin
          state_next = S_FIN;
        end else if (stat.n_one) begin
          state_next = S_MEAN;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = crcs_pkg::MSEL_DEN;
          state_next    = S_DEN;
        end
      end
      S_DEN: begin
        if (stat.mul_done) begin
          cmd.save_den = 1'b1;
          state_next   = S_MEAN;
        end
      end
      S_MEAN: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = crcs_pkg::DSEL_MEAN;
        state_next    = S_MEAN_W;
      end
      S_MEAN_W: begin
        if (stat.div_done) begin
          cmd.save_mean = 1'b1;
          state_next    = stat.n_one ? S_NEXT : S_SQ;
        end
      end
      S_SQ: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = crcs_pkg::MSEL_SQ;
        state_next    = S_SQ_W;
      end
      S_SQ_W: begin
        if (stat.mul_done) begin
          cmd.save_p1 = 1'b1;
          state_next  = S_SS;
        end
      end
      S_SS: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = crcs_pkg::MSEL_SS;
        state_next    = S_SS_W;
      end
      S_SS_W: begin
        if (stat.mul_done) begin
          cmd.save_num = 1'b1;
          state_next   = S_VAR;
        end
      end
      S_VAR: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = crcs_pkg::DSEL_VAR;
        state_next    = S_VAR_W;
      end
      S_VAR_W: begin
        cmd.div_sel = crcs_pkg::DSEL_VAR;
        if (stat.div_done) begin
          cmd.save_var = 1'b1;
          state_next   = S_NEXT;
        end
      end
      S_NEXT: begin
        if (ch == CH_LAST) begin
          state_next = S_FIN;
        end else begin
          ch_next    = ch + 2'd1;
          state_next = S_MEAN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_ACC;
        end
      end
      default: begin
        state_next = S_ACC;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/circle_region_color_stats_top.sv]
// Top level of the circle region color statistics block.
//
// Pixels arrive in raster order on the input channel (in_valid/in_stall) as
// blue, green and red bytes; frame_end marks the last pixel of a frame. While
// a frame streams in, one pixel is taken every cycle. Each pixel's position
// comes from internal column and row counters that wrap at image_width.
// After the frame_end transfer the input stalls while the result is built.
// An empty region needs no arithmetic and a single pixel only the mean
// divides; otherwise n*(n-1) is formed once, then each channel takes a mean
// divide, two products and a variance divide, all on one shared shift-add
// multiplier and one restoring divider, used in turn for the three channels.
// The result leaves on the output channel (out_valid/out_stall) from an output
// register; the next frame streams in while it waits. A stalled result holds
// its value, and a further frame end waits only if the previous result is
// still untaken when the new one is ready.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once
// and belong between frames. Reset clears the counters, the accumulators and
// out_valid, and restores the register reset values.
`default_nettype none

module circle_region_color_stats_top #(
  parameter int MAX_WIDTH   = crcs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = crcs_pkg::DEF_MAX_HEIGHT,
  parameter int EDGE_MARGIN = crcs_pkg::DEF_EDGE_MARGIN
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [crcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [crcs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [crcs_pkg::PIX_W-1:0]      blue,
  input  wire logic [crcs_pkg::PIX_W-1:0]      green,
  input  wire logic [crcs_pkg::PIX_W-1:0]      red,
  input  wire logic                           frame_end,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [crcs_pkg::CNT_W-1:0]          pixel_count,
  output logic [crcs_pkg::MEAN_W-1:0]         mean_blue,
  output logic [crcs_pkg::MEAN_W-1:0]         mean_green,
  output logic [crcs_pkg::MEAN_W-1:0]         mean_red,
  output logic [crcs_pkg::VAR_W-1:0]          var_blue,
  output logic [crcs_pkg::VAR_W-1:0]          var_green,
  output logic [crcs_pkg::VAR_W-1:0]          var_red,
  output logic [crcs_pkg::STATUS_W-1:0]       status
);

  crcs_pkg::crcs_cmd_t  cmd;
  crcs_pkg::crcs_stat_t stat;

  crcs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  crcs_dp #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .EDGE_MARGIN (EDGE_MARGIN)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .blue        (blue),
    .green       (green),
    .red         (red),
    .frame_end   (frame_end),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .pixel_count (pixel_count),
    .mean_blue   (mean_blue),
    .mean_green  (mean_green),
    .mean_red    (mean_red),
    .var_blue    (var_blue),
    .var_green   (var_green),
    .var_red     (var_red),
    .status      (status),
    .cmd         (cmd),
    .stat        (stat)
  );

  assign in_stall = !cmd.accept_en;

  // A frame end transfer closes the input until the result is built.
  a_stall_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && frame_end) |=> in_stall)
    else $error("input not stalled after frame end transfer");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == crcs_pkg::ST_EMPTY) |->
      (pixel_count == '0 && mean_blue == '0 && var_blue == '0))
    else $error("empty region result carries data");

  a_single_zero_var: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == crcs_pkg::ST_SINGLE) |->
      (pixel_count == crcs_pkg::CNT_W'(1) && var_blue == '0 &&
       var_green == '0 && var_red == '0))
    else $error("single pixel result has count or variance wrong");

  // A mean of 8-bit values never exceeds 255.0 in Q8.8.
  a_mean_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mean_blue <= 16'hFF00 && mean_green <= 16'hFF00 &&
                   mean_red <= 16'hFF00))
    else $error("mean out of range");

endmodule

`default_nettype wire
